// File: hdl/ysot_pkg.sv
// shared constants and types for the y sorted object table
package ysot_pkg;
    localparam int NUM_SLOTS = 8;
    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_MOVE   = 2'd2;
    localparam logic [1:0] FN_SCAN   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_UNUSED = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot;
        logic [2:0] pos;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] model;
        logic [2:0] ov;
        logic [3:0] count;
        logic       last;
    } t_result;
endpackage

// File: hdl/ysot_cmp.sv
// shared compare unit: 9 bit magnitude compare of two y values with offset
module ysot_cmp import ysot_pkg::*; (
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    input  logic [7:0] i_off,
    output logic       o_lt,
    output logic       o_gt
);
    logic [8:0] w_a;
    logic [8:0] w_b;
    assign w_a = {1'b0, i_a} + {1'b0, i_off};
    assign w_b = {1'b0, i_b};
    assign o_lt = w_a < w_b;
    assign o_gt = w_a > w_b;
endmodule

// File: hdl/y_sorted_object_table.sv
// top level: y sorted object table with sequencer and shared compare unit
// channel | dir | fields (tdata from bit 0)                 | tuser
// s_axis  | in  | target_slot, x_pos, y_pos, shape_model      | func
// m_axis  | out | status, slot, pos, x, y, model, ov, count   | -      tlast = last_result
// cfg     | in  | vertical_interval                          | -
// insert, delete: insert bubbles in from the tail, delete searches then closes the gap
// move: search then bubble, one compare per cycle
// scan: each object's overlap count is found through the single comparator
// each result waits in the output register until taken; not ready meanwhile
// reset clears valid marks, overlap counts, count and sets interval to 12
module y_sorted_object_table import ysot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // target_slot[2:0], x_pos[10:3], y_pos[18:11], shape_model[26:19], zero fill
    input  logic [31:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], result_slot[4:2], sorted_position[7:5], out_x[15:8],
    // out_y[23:16], out_model[31:24], overlap_count[34:32], object_count[38:35]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_FIND = 7'b0000010, S_INS = 7'b0000100,
        S_DEL  = 7'b0001000, S_MOVE = 7'b0010000, S_SCAN = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    logic [7:0] r_vi;
    logic [7:0] r_x [NUM_SLOTS];
    logic [7:0] r_y [NUM_SLOTS];
    logic [7:0] r_m [NUM_SLOTS];
    logic [SW-1:0] r_ord [NUM_SLOTS];
    logic [2:0] r_ovl [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    logic [CW-1:0] r_live;
    logic [1:0] r_fn;
    logic [SW-1:0] r_tgt;
    logic [7:0] r_xi, r_yi, r_mi;
    logic [CW-1:0] r_p, r_q;
    logic r_down, r_ret_scan;
    logic [2:0] r_cnt;
    t_result r_res;

    logic [7:0] w_a, w_b, w_off;
    logic w_lt, w_gt;
    logic [SW-1:0] w_free;
    logic [CW-1:0] w_pm1, w_pp1;
    logic [SW-1:0] w_cur;
    logic w_scan_last;

    assign w_pm1 = r_p - CW'(1);
    assign w_pp1 = r_p + CW'(1);
    assign w_cur = r_ord[r_p[SW-1:0]];
    assign w_scan_last = (w_pp1 == r_live) || (r_p == CW'(7));

    ysot_cmp u_cmp (.i_a(w_a), .i_b(w_b), .i_off(w_off), .o_lt(w_lt), .o_gt(w_gt));

    always_comb begin
        w_a = r_yi;
        w_b = r_y[r_ord[w_pm1[SW-1:0]]];
        w_off = 8'd0;
        if (r_state == S_MOVE && r_down) begin
            w_b = r_y[r_ord[w_pp1[SW-1:0]]];
        end else if (r_state == S_SCAN) begin
            w_a = r_y[r_ord[r_p[SW-1:0]]];
            w_b = r_y[r_ord[r_q[SW-1:0]]];
            w_off = r_vi;
        end
    end

    always_comb begin
        w_free = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) w_free = SW'(i);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tlast = r_res.last;
    assign m_axis_tdata = {1'b0, r_res.count, r_res.ov, r_res.model, r_res.y, r_res.x,
                           r_res.pos, r_res.slot, r_res.status};

    function automatic t_result f_err(input logic [1:0] st, input logic [CW-1:0] n);
        t_result r;
        r = '0;
        r.status = st;
        r.count = 4'(n);
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_result f_obj(input logic [SW-1:0] s, input logic [CW-1:0] p,
                                      input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] m, input logic [2:0] ov,
                                      input logic [CW-1:0] n, input logic last);
        t_result r;
        r.status = ST_OK;
        r.slot = 3'(s);
        r.pos = 3'(p);
        r.x = x;
        r.y = y;
        r.model = m;
        r.ov = ov;
        r.count = 4'(n);
        r.last = last;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vi <= 8'd12;
            r_valid <= '0;
            r_live <= '0;
            r_ret_scan <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) r_ovl[i] <= 3'd0;
        end else begin
            if (i_cfg_we) r_vi <= i_cfg_wdata;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_fn <= s_axis_tuser;
                        r_tgt <= s_axis_tdata[SW-1:0];
                        r_xi <= s_axis_tdata[10:3];
                        r_yi <= s_axis_tdata[18:11];
                        r_mi <= s_axis_tdata[26:19];
                        r_ret_scan <= 1'b0;
                        if (s_axis_tuser == FN_INSERT) begin
                            if (r_live == CW'(NUM_SLOTS)) begin
                                r_res <= f_err(ST_FULL, r_live);
                                r_state <= S_OUT;
                            end else begin
                                r_p <= r_live;
                                r_state <= S_INS;
                            end
                        end else if (r_live == '0) begin
                            r_res <= f_err(ST_EMPTY, r_live);
                            r_state <= S_OUT;
                        end else if (s_axis_tuser == FN_SCAN) begin
                            r_p <= '0;
                            r_q <= CW'(1);
                            r_cnt <= 3'd0;
                            r_state <= S_SCAN;
                        end else if (!r_valid[s_axis_tdata[SW-1:0]]) begin
                            r_res <= f_err(ST_UNUSED, r_live);
                            r_state <= S_OUT;
                        end else begin
                            r_p <= '0;
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    if (r_ord[r_p[SW-1:0]] == r_tgt) begin
                        if (r_fn == FN_DELETE) begin
                            r_res <= f_obj(r_tgt, r_p, r_x[r_tgt], r_y[r_tgt], r_m[r_tgt],
                                           3'd0, r_live - CW'(1), 1'b1);
                            r_valid[r_tgt] <= 1'b0;
                            r_state <= S_DEL;
                        end else begin
                            r_x[r_tgt] <= r_xi;
                            r_down <= r_y[r_tgt] < r_yi;
                            r_y[r_tgt] <= r_yi;
                            r_state <= S_MOVE;
                        end
                    end else r_p <= w_pp1;
                end
                S_DEL: begin
                    if (w_pp1 < r_live) begin
                        r_ord[r_p[SW-1:0]] <= r_ord[w_pp1[SW-1:0]];
                        r_p <= w_pp1;
                    end else begin
                        r_live <= r_live - CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_INS: begin
                    if (r_p != '0 && w_lt) begin
                        r_ord[r_p[SW-1:0]] <= r_ord[w_pm1[SW-1:0]];
                        r_p <= w_pm1;
                    end else begin
                        r_ord[r_p[SW-1:0]] <= w_free;
                        r_x[w_free] <= r_xi;
                        r_y[w_free] <= r_yi;
                        r_m[w_free] <= r_mi;
                        r_valid[w_free] <= 1'b1;
                        r_live <= r_live + CW'(1);
                        r_res <= f_obj(w_free, r_p, r_xi, r_yi, r_mi, 3'd0,
                                       r_live + CW'(1), 1'b1);
                        r_state <= S_OUT;
                    end
                end
                S_MOVE: begin
                    if (r_down && w_pp1 < r_live && w_gt) begin
                        r_ord[r_p[SW-1:0]] <= r_ord[w_pp1[SW-1:0]];
                        r_p <= w_pp1;
                    end else if (!r_down && r_p != '0 && w_lt) begin
                        r_ord[r_p[SW-1:0]] <= r_ord[w_pm1[SW-1:0]];
                        r_p <= w_pm1;
                    end else begin
                        r_ord[r_p[SW-1:0]] <= r_tgt;
                        r_res <= f_obj(r_tgt, r_p, r_xi, r_y[r_tgt], r_m[r_tgt], 3'd0,
                                       r_live, 1'b1);
                        r_state <= S_OUT;
                    end
                end
                S_SCAN: begin
                    if (r_q < r_live && !w_lt) begin
                        r_q <= r_q + CW'(1);
                        if (r_cnt != 3'd7) r_cnt <= r_cnt + 3'd1;
                    end else begin
                        r_ovl[w_cur] <= r_cnt;
                        r_res <= f_obj(w_cur, r_p, r_x[w_cur], r_y[w_cur], r_m[w_cur],
                                       r_cnt, r_live, w_scan_last);
                        r_ret_scan <= !w_scan_last;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_ret_scan) begin
                            r_p <= w_pp1;
                            r_q <= r_p + CW'(2);
                            r_cnt <= 3'd0;
                            r_state <= S_SCAN;
                        end else r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(NUM_SLOTS)) else $error("live count out of range");
    a_live_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> $countones(r_valid) == int'(r_live))
        else $error("valid marks disagree with count");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_no_overlap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
`endif
endmodule

// File: verif/testbench.sv
// testbench for the y sorted object table: directed table, random traffic, predictor checks
`timescale 1ns / 100ps
module testbench;
    import ysot_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    y_sorted_object_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    typedef struct {
        logic [1:0] func;
        logic [2:0] slot;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] model;
        logic       typed;
        logic [1:0] want_status;
        logic [3:0] want_count;
    } t_request;

    // table shadow
    logic [7:0] tbl_x[NUM_SLOTS];
    logic [7:0] tbl_y[NUM_SLOTS];
    logic [7:0] tbl_model[NUM_SLOTS];
    logic       tbl_valid[NUM_SLOTS];
    logic [2:0] y_order[NUM_SLOTS];
    int         live;
    logic [7:0] interval;

    t_result    expected_results[$];
    int         errors;
    int         results_seen;
    int         requests_sent;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         op_hits[4];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic t_result blank_result(input logic [1:0] st);
        t_result r;
        r = '0;
        r.status = st;
        r.count = 4'(live);
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_result object_result(input int s, input int p, input int ov,
                                              input logic last);
        t_result r;
        r.status = ST_OK;
        r.slot = 3'(s);
        r.pos = 3'(p);
        r.x = tbl_x[s];
        r.y = tbl_y[s];
        r.model = tbl_model[s];
        r.ov = 3'(ov > 7 ? 7 : ov);
        r.count = 4'(live);
        r.last = last;
        return r;
    endfunction

    // applies one request to the shadow table and queues its results
    task automatic predict_table_op(input t_request rq);
        int s, p, q, cnt, lim;
        logic down;
        if (rq.func == FN_INSERT) begin
            if (live >= NUM_SLOTS) begin
                expected_results.push_back(blank_result(ST_FULL));
                return;
            end
            for (s = 0; s < NUM_SLOTS; s++)
                if (!tbl_valid[s]) break;
            p = live;
            while (p > 0 && rq.y < tbl_y[y_order[p-1]]) begin
                y_order[p] = y_order[p-1];
                p--;
            end
            y_order[p] = 3'(s);
            tbl_x[s] = rq.x;
            tbl_y[s] = rq.y;
            tbl_model[s] = rq.model;
            tbl_valid[s] = 1'b1;
            live++;
            expected_results.push_back(object_result(s, p, 0, 1'b1));
            return;
        end
        if (live == 0) begin
            expected_results.push_back(blank_result(ST_EMPTY));
            return;
        end
        if (rq.func == FN_SCAN) begin
            for (p = 0; p < live; p++) begin
                lim = int'(tbl_y[y_order[p]]) + int'(interval);
                cnt = 0;
                for (q = p + 1; q < live; q++) begin
                    if (int'(tbl_y[y_order[q]]) > lim) break;
                    cnt++;
                end
                expected_results.push_back(object_result(int'(y_order[p]), p, cnt,
                                                         p + 1 == live));
            end
            return;
        end
        s = int'(rq.slot);
        if (!tbl_valid[s]) begin
            expected_results.push_back(blank_result(ST_UNUSED));
            return;
        end
        for (p = 0; p < live; p++)
            if (y_order[p] == 3'(s)) break;
        if (rq.func == FN_DELETE) begin
            for (q = p; q + 1 < live; q++)
                y_order[q] = y_order[q+1];
            tbl_valid[s] = 1'b0;
            live--;
            expected_results.push_back(object_result(s, p, 0, 1'b1));
            return;
        end
        tbl_x[s] = rq.x;
        if (tbl_y[s] != rq.y) begin
            down = tbl_y[s] < rq.y;
            tbl_y[s] = rq.y;
            if (down) begin
                while (p + 1 < live && rq.y > tbl_y[y_order[p+1]]) begin
                    y_order[p] = y_order[p+1];
                    p++;
                end
            end else begin
                while (p > 0 && rq.y < tbl_y[y_order[p-1]]) begin
                    y_order[p] = y_order[p-1];
                    p--;
                end
            end
            y_order[p] = 3'(s);
        end
        expected_results.push_back(object_result(s, p, 0, 1'b1));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.slot = m_axis_tdata[4:2];
            got.pos = m_axis_tdata[7:5];
            got.x = m_axis_tdata[15:8];
            got.y = m_axis_tdata[23:16];
            got.model = m_axis_tdata[31:24];
            got.ov = m_axis_tdata[34:32];
            got.count = m_axis_tdata[38:35];
            got.last = m_axis_tlast;
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 8'(got.status), 8'(want.status));
                if (got.slot !== want.slot)
                    report_mismatch("slot", 8'(got.slot), 8'(want.slot));
                if (got.pos !== want.pos)
                    report_mismatch("position", 8'(got.pos), 8'(want.pos));
                if (got.x !== want.x) report_mismatch("x", got.x, want.x);
                if (got.y !== want.y) report_mismatch("y", got.y, want.y);
                if (got.model !== want.model) report_mismatch("model", got.model, want.model);
                if (got.ov !== want.ov)
                    report_mismatch("overlap", 8'(got.ov), 8'(want.ov));
                if (got.count !== want.count)
                    report_mismatch("count", 8'(got.count), 8'(want.count));
                if (got.last !== want.last)
                    report_mismatch("last", 8'(got.last), 8'(want.last));
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(input t_request rq);
        t_result chk;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rq.func;
        s_axis_tdata <= {5'd0, rq.model, rq.y, rq.x, rq.slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        requests_sent++;
        op_hits[rq.func]++;
        if (rq.typed) begin
            chk = '0;
            chk.status = rq.want_status;
            chk.count = rq.want_count;
            chk.last = 1'b1;
            expected_results.push_back(chk);
        end else begin
            predict_table_op(rq);
        end
    endtask

    task automatic drain_and_settle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        interval = v;
    endtask

    function automatic t_request make_req(input logic [1:0] f, input int s, input int x,
                                          input int y, input int m);
        t_request rq;
        rq.func = f;
        rq.slot = 3'(s);
        rq.x = 8'(x);
        rq.y = 8'(y);
        rq.model = 8'(m);
        rq.typed = 1'b0;
        rq.want_status = ST_OK;
        rq.want_count = 4'd0;
        return rq;
    endfunction

    function automatic t_request random_req();
        int r, s;
        logic [1:0] f;
        r = $urandom_range(99);
        if (live < 3) f = (r < 70) ? FN_INSERT : 2'($urandom_range(3));
        else if (r < 35) f = FN_INSERT;
        else if (r < 55) f = FN_DELETE;
        else if (r < 85) f = FN_MOVE;
        else f = FN_SCAN;
        s = $urandom_range(NUM_SLOTS - 1);
        if ($urandom_range(9) < 8 && live > 0) s = int'(y_order[$urandom_range(live - 1)]);
        if ($urandom_range(3) == 0)
            return make_req(f, s, $urandom, $urandom_range(40) + 100, $urandom);
        return make_req(f, s, $urandom, $urandom, $urandom);
    endfunction

    initial begin
        t_request plan[$];
        t_request rq;
        int phase, k;
        errors = 0;
        results_seen = 0;
        requests_sent = 0;
        live = 0;
        interval = 8'd12;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (k = 0; k < NUM_SLOTS; k++) tbl_valid[k] = 1'b0;
        for (k = 0; k < 4; k++) op_hits[k] = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FN_INSERT;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty errors, fill, full, unused slot, extremes
        rq = make_req(FN_DELETE, 0, 0, 0, 0); rq.typed = 1'b1; rq.want_status = ST_EMPTY;
        plan.push_back(rq);
        rq = make_req(FN_MOVE, 7, 255, 255, 255); rq.typed = 1'b1; rq.want_status = ST_EMPTY;
        plan.push_back(rq);
        rq = make_req(FN_SCAN, 0, 0, 0, 0); rq.typed = 1'b1; rq.want_status = ST_EMPTY;
        plan.push_back(rq);
        plan.push_back(make_req(FN_INSERT, 0, 255, 255, 255));
        plan.push_back(make_req(FN_INSERT, 7, 0, 0, 0));
        plan.push_back(make_req(FN_INSERT, 0, 170, 20, 85));
        plan.push_back(make_req(FN_INSERT, 0, 85, 20, 170));
        plan.push_back(make_req(FN_INSERT, 0, 1, 250, 2));
        plan.push_back(make_req(FN_INSERT, 0, 3, 8, 4));
        plan.push_back(make_req(FN_INSERT, 0, 5, 12, 6));
        plan.push_back(make_req(FN_INSERT, 0, 7, 255, 8));
        rq = make_req(FN_INSERT, 0, 9, 9, 9); rq.typed = 1'b1; rq.want_status = ST_FULL;
        rq.want_count = 4'd8;
        plan.push_back(rq);
        plan.push_back(make_req(FN_SCAN, 0, 0, 0, 0));
        plan.push_back(make_req(FN_MOVE, 1, 11, 200, 0));
        plan.push_back(make_req(FN_MOVE, 0, 12, 0, 0));
        plan.push_back(make_req(FN_MOVE, 2, 13, 20, 0));
        plan.push_back(make_req(FN_DELETE, 3, 0, 0, 0));
        rq = make_req(FN_DELETE, 3, 0, 0, 0); rq.typed = 1'b1; rq.want_status = ST_UNUSED;
        rq.want_count = 4'd7;
        plan.push_back(rq);
        rq = make_req(FN_MOVE, 3, 0, 0, 0); rq.typed = 1'b1; rq.want_status = ST_UNUSED;
        rq.want_count = 4'd7;
        plan.push_back(rq);
        plan.push_back(make_req(FN_INSERT, 0, 14, 128, 15));
        plan.push_back(make_req(FN_SCAN, 0, 0, 0, 0));
        foreach (plan[i]) send_request(plan[i]);
        drain_and_settle();
        write_interval(8'd255);
        send_request(make_req(FN_SCAN, 0, 0, 0, 0));
        drain_and_settle();
        write_interval(8'd0);
        send_request(make_req(FN_SCAN, 0, 0, 0, 0));
        drain_and_settle();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 54 : (phase == 3) ? 33 : 0;
            recv_stall_pct = (phase == 2) ? 54 : (phase == 3) ? 33 : 0;
            for (k = 0; k < 35; k++) begin
                send_request(random_req());
                if (k == 20) begin
                    s_axis_tvalid <= 1'b0;
                    while (expected_results.size() != 0) @(posedge i_clk);
                end
            end
            drain_and_settle();
            write_interval((phase == 3) ? 8'd12 : 8'($urandom));
        end
        send_request(make_req(FN_SCAN, 0, 0, 0, 0));
        drain_and_settle();

        $display("requests %0d (insert %0d delete %0d move %0d scan %0d), results %0d",
                 requests_sent, op_hits[0], op_hits[1], op_hits[2], op_hits[3],
                 results_seen);
        $display("interval settings 12, 255, 0 and random; idle and stall mixes covered");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors, %0d results outstanding", errors, expected_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
